>>> rtl/core/yuyv_pair_color_converter_top_macros.svh
// ----------------------------------------------------------------------------
// YUYV pair color converter assertion macros
// Shared assertion wrappers for the converter checker.
// ----------------------------------------------------------------------------
`ifndef YUYV_PAIR_COLOR_CONVERTER_TOP_MACROS_SVH
`define YUYV_PAIR_COLOR_CONVERTER_TOP_MACROS_SVH

// Checked on every edge outside reset.
`define YCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define YCC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/yuyvcc_pkg.sv
// ----------------------------------------------------------------------------
// YUYV pair color converter package
// Output modes, payload types and fixed-point constants.
// ----------------------------------------------------------------------------
package yuyvcc_pkg;

  typedef enum logic [1:0] {
    MODE_GRAY  = 2'd0,
    MODE_COLOR = 2'd1,
    MODE_YUV   = 2'd2
  } mode_t;

  localparam mode_t MODE_RESET = MODE_COLOR;

  // Chroma terms fit 17 bits signed; the full sum with luma and rounding fits 19.
  localparam int ADD_W = 17;
  localparam int SUM_W = 19;

  localparam logic signed [ADD_W-1:0] COEF_CR_RED   = 17'sd358;
  localparam logic signed [ADD_W-1:0] COEF_CB_GREEN = -17'sd87;
  localparam logic signed [ADD_W-1:0] COEF_CR_GREEN = -17'sd181;
  localparam logic signed [ADD_W-1:0] COEF_CB_BLUE  = 17'sd451;
  localparam logic signed [SUM_W-1:0] ROUND_HALF    = 19'sd128;
  localparam logic [7:0]              COMP_MAX      = 8'd255;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
  } macropix_t;

  typedef struct packed {
    logic [7:0] comp_a;
    logic [7:0] comp_b;
    logic [7:0] comp_c;
  } pix_t;

endpackage

>>> rtl/core/yuyvcc_clamp.sv
// ----------------------------------------------------------------------------
// YUYV color converter component finish
// Adds scaled luma, chroma term and rounding, shifts by 8, clamps to 0..255.
// ----------------------------------------------------------------------------
module yuyvcc_clamp import yuyvcc_pkg::*; (
  input  logic [7:0]              luma,
  input  logic signed [ADD_W-1:0] chroma_add,
  output logic [7:0]              comp
);

  logic signed [SUM_W-1:0] sum;

  assign sum = $signed({{(SUM_W-16){1'b0}}, luma, 8'd0}) + SUM_W'(chroma_add) + ROUND_HALF;

  always_comb begin
    if (sum[SUM_W-1]) begin
      comp = 8'd0;
    end else if (|sum[SUM_W-2:16]) begin
      comp = COMP_MAX;
    end else begin
      comp = sum[15:8];
    end
  end

endmodule

>>> rtl/core/yuyvcc_convert.sv
// ----------------------------------------------------------------------------
// YUYV color converter datapath
// One macropixel in, two three-component pixels out, per the output mode.
// ----------------------------------------------------------------------------
module yuyvcc_convert import yuyvcc_pkg::*; (
  input  mode_t     mode,
  input  macropix_t mpix,
  output pix_t      pix_first,
  output pix_t      pix_second
);

  logic signed [8:0]       cbs;
  logic signed [8:0]       crs;
  logic signed [ADD_W-1:0] add_r;
  logic signed [ADD_W-1:0] add_g;
  logic signed [ADD_W-1:0] add_b;
  pix_t                    rgb_first;
  pix_t                    rgb_second;

  // Offset binary minus 128: flip the top bit, read as two's complement
  assign cbs = $signed({~mpix.chroma_blue[7], ~mpix.chroma_blue[7], mpix.chroma_blue[6:0]});
  assign crs = $signed({~mpix.chroma_red[7], ~mpix.chroma_red[7], mpix.chroma_red[6:0]});

  assign add_r = ADD_W'(crs) * COEF_CR_RED;
  assign add_g = ADD_W'(cbs) * COEF_CB_GREEN + ADD_W'(crs) * COEF_CR_GREEN;
  assign add_b = ADD_W'(cbs) * COEF_CB_BLUE;

  yuyvcc_clamp u_first_b (.luma(mpix.luma_first),  .chroma_add(add_b), .comp(rgb_first.comp_a));
  yuyvcc_clamp u_first_g (.luma(mpix.luma_first),  .chroma_add(add_g), .comp(rgb_first.comp_b));
  yuyvcc_clamp u_first_r (.luma(mpix.luma_first),  .chroma_add(add_r), .comp(rgb_first.comp_c));
  yuyvcc_clamp u_second_b(.luma(mpix.luma_second), .chroma_add(add_b), .comp(rgb_second.comp_a));
  yuyvcc_clamp u_second_g(.luma(mpix.luma_second), .chroma_add(add_g), .comp(rgb_second.comp_b));
  yuyvcc_clamp u_second_r(.luma(mpix.luma_second), .chroma_add(add_r), .comp(rgb_second.comp_c));

  always_comb begin
    pix_first  = '0;
    pix_second = '0;
    case (mode)
      MODE_GRAY: begin
        pix_first.comp_a  = mpix.luma_first;
        pix_second.comp_a = mpix.luma_second;
      end
      MODE_COLOR: begin
        pix_first  = rgb_first;
        pix_second = rgb_second;
      end
      MODE_YUV: begin
        pix_first  = '{comp_a: mpix.luma_first,  comp_b: mpix.chroma_blue,
                       comp_c: mpix.chroma_red};
        pix_second = '{comp_a: mpix.luma_second, comp_b: mpix.chroma_blue,
                       comp_c: mpix.chroma_red};
      end
      default: begin
        // unused mode code: all components zero
        pix_first  = '0;
        pix_second = '0;
      end
    endcase
  end

endmodule

>>> rtl/core/yuyv_pair_color_converter_top.sv
// ----------------------------------------------------------------------------
// YUYV pair color converter
// Converts one YUYV macropixel per beat into two 3-byte output pixels.
// ----------------------------------------------------------------------------
// Each accepted macropixel gives one result beat holding two pixels, via the
// input register and then the result register. The block takes one beat per
// cycle while the output is not stalled: these registers bracket a single
// pass of constant-coefficient multiply, add and clamp logic, and both stages
// advance together whenever the result side can take data.
// cfg_wr_data selects the format (0 gray, 1 blue/green/red, 2 luma/Cb/Cr;
// reset gives blue/green/red) and should only change while no beat is in
// flight.
module yuyv_pair_color_converter_top import yuyvcc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_luma_first,
  input  logic [7:0] in_chroma_blue,
  input  logic [7:0] in_luma_second,
  input  logic [7:0] in_chroma_red,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_first_comp_a,
  output logic [7:0] out_first_comp_b,
  output logic [7:0] out_first_comp_c,
  output logic [7:0] out_second_comp_a,
  output logic [7:0] out_second_comp_b,
  output logic [7:0] out_second_comp_c
);

  mode_t     mode_r;
  logic      in_valid_r;
  macropix_t mpix_r;
  logic      out_valid_r;
  pix_t      first_r;
  pix_t      second_r;
  pix_t      first_nxt;
  pix_t      second_nxt;
  logic      out_load;

  // result register free or emptying this cycle
  assign out_load = !out_valid_r || out_ready;
  assign in_ready = !in_valid_r || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_RESET;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= mode_t'(cfg_wr_data);
      end
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (out_load) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      mpix_r <= '{luma_first: in_luma_first, chroma_blue: in_chroma_blue,
                  luma_second: in_luma_second, chroma_red: in_chroma_red};
    end
    if (out_load && in_valid_r) begin
      first_r  <= first_nxt;
      second_r <= second_nxt;
    end
  end

  yuyvcc_convert u_convert (
    .mode      (mode_r),
    .mpix      (mpix_r),
    .pix_first (first_nxt),
    .pix_second(second_nxt)
  );

  assign out_valid         = out_valid_r;
  assign out_first_comp_a  = first_r.comp_a;
  assign out_first_comp_b  = first_r.comp_b;
  assign out_first_comp_c  = first_r.comp_c;
  assign out_second_comp_a = second_r.comp_a;
  assign out_second_comp_b = second_r.comp_b;
  assign out_second_comp_c = second_r.comp_c;

endmodule

>>> rtl/core/yuyvcc_checker.sv
// ----------------------------------------------------------------------------
// YUYV pair color converter checker
// Port-level checks on flow, occupancy and mode-dependent output content.
// ----------------------------------------------------------------------------
`include "yuyv_pair_color_converter_top_macros.svh"

module yuyvcc_checker import yuyvcc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       cfg_wr_en,
  input logic [1:0] cfg_wr_data,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_first_comp_a,
  input logic [7:0] out_first_comp_b,
  input logic [7:0] out_first_comp_c,
  input logic [7:0] out_second_comp_a,
  input logic [7:0] out_second_comp_b,
  input logic [7:0] out_second_comp_c
);

  logic [1:0] mode_r;
  logic [1:0] out_mode_r;
  logic [1:0] inflight_r;
  logic       in_beat;
  logic       out_beat;
  logic       gray_or_unused;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  // mirror of the mode register, and the mode held by the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_RESET;
      out_mode_r <= MODE_RESET;
      inflight_r <= 2'd0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (!out_valid || out_ready) begin
        out_mode_r <= mode_r;
      end
      inflight_r <= inflight_r + 2'(in_beat) - 2'(out_beat);
    end
  end

  // gray mode and the unused code both leave chroma components at zero
  assign gray_or_unused = (out_mode_r != MODE_COLOR) && (out_mode_r != MODE_YUV);

  `YCC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "out_valid after reset")

  `YCC_ASSERT(a_occupancy,
    (inflight_r != 2'd3) && (!out_valid || inflight_r != 2'd0),
    "beats in flight out of range")

  `YCC_ASSERT(a_stall_hold,
    out_valid && !out_ready |=> out_valid && $stable(out_first_comp_a)
      && $stable(out_second_comp_c),
    "result changed while stalled")

  `YCC_ASSERT(a_gray_chroma,
    out_valid && gray_or_unused |-> out_first_comp_b == 8'd0 && out_first_comp_c == 8'd0
      && out_second_comp_b == 8'd0 && out_second_comp_c == 8'd0,
    "chroma nonzero in gray mode")

  `YCC_ASSERT(a_yuv_shared,
    out_valid && out_mode_r == MODE_YUV |-> out_first_comp_b == out_second_comp_b
      && out_first_comp_c == out_second_comp_c,
    "yuv chroma differs between pixels")

endmodule

bind yuyv_pair_color_converter_top yuyvcc_checker u_yuyvcc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .cfg_wr_en        (cfg_wr_en),
  .cfg_wr_data      (cfg_wr_data),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_first_comp_a (out_first_comp_a),
  .out_first_comp_b (out_first_comp_b),
  .out_first_comp_c (out_first_comp_c),
  .out_second_comp_a(out_second_comp_a),
  .out_second_comp_b(out_second_comp_b),
  .out_second_comp_c(out_second_comp_c)
);
